[rtl/core/idwt97_pkg.sv]
`default_nettype none

package idwt97_pkg;

   localparam int SAMPLE_W = 20;
   localparam int TAP_W    = 16;
   localparam int PROD_W   = SAMPLE_W + TAP_W;
   localparam int ACC_W    = PROD_W + 4;
   localparam int IDX_W    = 6;
   localparam int SIDE_W   = 7;
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int LINE_DEPTH  = 1 << IDX_W;
   localparam int TAP_COUNT   = 16;
   localparam int LOW_COUNT   = 7;
   localparam int ROUND_SHIFT = 14;

   localparam logic [SIDE_W-1:0] SIDE_MIN   = 7'd8;
   localparam logic [SIDE_W-1:0] SIDE_MAX   = 7'd64;
   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

   // Tap step counter: issue on 0..15, drain on 16..17, write back on the last
   localparam logic [4:0] STEP_ISSUE_END = 5'd16;
   localparam logic [4:0] STEP_WRITE     = 5'd18;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FILT,
      ST_ACK,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

   typedef struct packed {
      logic issue;
      logic clear;
   } mac_ctrl_type;

   // Q1.14 synthesis taps: low filter on steps 0..6, high filter on steps 7..15
   function automatic logic signed [TAP_W-1:0] tap_value(input logic [3:0] step);
      logic signed [TAP_W-1:0] v;
      begin
         unique case (step)
            4'd0:  v = -16'sd1495;
            4'd1:  v = -16'sd943;
            4'd2:  v = 16'sd9687;
            4'd3:  v = 16'sd18270;
            4'd4:  v = 16'sd9687;
            4'd5:  v = -16'sd943;
            4'd6:  v = -16'sd1495;
            4'd7:  v = 16'sd438;
            4'd8:  v = 16'sd276;
            4'd9:  v = -16'sd1282;
            4'd10: v = -16'sd4401;
            4'd11: v = 16'sd9879;
            4'd12: v = -16'sd4401;
            4'd13: v = -16'sd1282;
            4'd14: v = 16'sd276;
            4'd15: v = 16'sd438;
            default: v = '0;
         endcase
         tap_value = v;
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/idwt97_mac.sv]
`default_nettype none

module idwt97_mac (
   input  wire logic                                      clock,
   input  wire logic signed [idwt97_pkg::SAMPLE_W-1:0]    operand,
   input  wire logic signed [idwt97_pkg::TAP_W-1:0]       tap,
   input  wire idwt97_pkg::mac_ctrl_type                  ctrl,
   output logic signed [idwt97_pkg::SAMPLE_W-1:0]         result
);

   localparam int SHIFTED_W = idwt97_pkg::ACC_W - idwt97_pkg::ROUND_SHIFT;

   logic                                         issue_ff;
   logic                                         add_ff;
   logic signed [idwt97_pkg::PROD_W-1:0]         prod_ff;
   logic signed [idwt97_pkg::ACC_W-1:0]          acc_ff;
   logic signed [idwt97_pkg::ACC_W-1:0]          acc_in;
   logic signed [idwt97_pkg::ACC_W-1:0]          biased;
   logic signed [SHIFTED_W-1:0]                  shifted;
   logic signed [SHIFTED_W-1:0]                  sat_hi;
   logic signed [SHIFTED_W-1:0]                  sat_lo;

   always_ff @(posedge clock) begin
      issue_ff <= ctrl.issue;
      add_ff   <= issue_ff;
      prod_ff  <= operand * tap;
      acc_ff   <= acc_in;
   end

   always_comb begin
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (add_ff) begin
         acc_in = acc_ff + idwt97_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // Round half up from Q.18 to Q.4, then saturate
   always_comb begin
      biased  = acc_ff + idwt97_pkg::ACC_W'(1 << (idwt97_pkg::ROUND_SHIFT - 1));
      shifted = SHIFTED_W'(biased >>> idwt97_pkg::ROUND_SHIFT);
      sat_hi  = SHIFTED_W'((1 << (idwt97_pkg::SAMPLE_W - 1)) - 1);
      sat_lo  = -sat_hi - SHIFTED_W'(1);
      priority if (shifted > sat_hi) begin
         result = idwt97_pkg::SAMPLE_W'(sat_hi);
      end else if (shifted < sat_lo) begin
         result = idwt97_pkg::SAMPLE_W'(sat_lo);
      end else begin
         result = idwt97_pkg::SAMPLE_W'(shifted);
      end
   end

endmodule

`default_nettype wire

[rtl/core/inverse_dwt97_2d_level_top.sv]
`default_nettype none
// Channel  Direction  Handshake        Payload
// req      in         valid / stall    command, row_index, col_index, coeff_value
// rsp      out        valid / stall    sample_value, out_row, out_col, last_flag
// csr      in         valid / ready    block_size
//
// Write goes straight into the store. Read streams one row through the store's registered
// read port, alternating address and data states per sample, and holds on output stalls.
// Run loads each line of side n, then runs each sample through the 16 tap steps on the one
// shared multiply-accumulate unit and drains its tap, product and accumulator registers.
// Reset is synchronous and clears control state only; the store is undefined until written.
// Output stalls hold the sequencer only while a result waits in the output register.

module inverse_dwt97_2d_level_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_command,
   input  wire logic [idwt97_pkg::IDX_W-1:0]           req_row_index,
   input  wire logic [idwt97_pkg::IDX_W-1:0]           req_col_index,
   input  wire logic signed [idwt97_pkg::SAMPLE_W-1:0] req_coeff_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [idwt97_pkg::SAMPLE_W-1:0]      rsp_sample_value,
   output logic [idwt97_pkg::IDX_W-1:0]                rsp_out_row,
   output logic [idwt97_pkg::IDX_W-1:0]                rsp_out_col,
   output logic                                        rsp_last_flag,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [idwt97_pkg::SIDE_W-1:0]          csr_block_size
);

   localparam int IW = idwt97_pkg::IDX_W;
   localparam int SW = idwt97_pkg::SIDE_W;
   localparam int DW = idwt97_pkg::SAMPLE_W;

   idwt97_pkg::state_type state_ff, state_in;

   logic [SW-1:0]  block_size_ff;
   logic           done_ff;
   logic           pass_ff;
   logic [IW-1:0]  line_ff;
   logic [SW-1:0]  idx_ff;
   logic [IW-1:0]  pos_ff;
   logic [4:0]     step_ff;
   logic [IW-1:0]  row_ff;
   logic [IW-1:0]  col_ff;

   logic           rsp_valid_ff;
   logic [DW-1:0]  rsp_value_ff;
   logic [IW-1:0]  rsp_row_ff;
   logic [IW-1:0]  rsp_col_ff;
   logic           rsp_last_ff;

   logic [DW-1:0]  store_mem [idwt97_pkg::STORE_DEPTH];
   logic [DW-1:0]  store_rd_ff;
   logic [DW-1:0]  line_mem [idwt97_pkg::LINE_DEPTH];
   logic signed [DW-1:0] line_rd_ff;
   logic signed [idwt97_pkg::TAP_W-1:0] tap_ff;

   logic [SW-1:0]  side_raw;
   logic [SW-1:0]  side;
   logic [SW-1:0]  side_m1;
   logic           req_accept;
   logic           slot_free;
   logic           rsp_load;
   logic           load_done;
   logic           sample_done;
   logic           line_last;
   logic           col_last;
   logic           read_ok;

   logic                         store_we;
   logic [idwt97_pkg::ADDR_W-1:0] store_wa;
   logic [DW-1:0]                store_wd;
   logic [idwt97_pkg::ADDR_W-1:0] store_ra;
   logic [IW-1:0]                elem;

   logic signed [7:0]            tap_pos;
   logic [SW-1:0]                mag;
   logic [SW-1:0]                fold_pos;
   logic                         is_low;
   logic                         tap_used;
   logic [IW-1:0]                line_ra;

   idwt97_pkg::mac_ctrl_type     mac_ctrl;
   logic signed [DW-1:0]         mac_result;

   // Effective side: even, clamped to 8..64
   always_comb begin
      side_raw = block_size_ff & 7'h7E;
      priority if (side_raw < idwt97_pkg::SIDE_MIN) begin
         side = idwt97_pkg::SIDE_MIN;
      end else if (side_raw > idwt97_pkg::SIDE_MAX) begin
         side = idwt97_pkg::SIDE_MAX;
      end else begin
         side = side_raw;
      end
      side_m1 = side - SW'(1);
   end

   assign req_stall   = (state_ff != idwt97_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign load_done   = (idx_ff == side);
   assign sample_done = (step_ff == idwt97_pkg::STEP_WRITE);
   assign line_last   = ({1'b0, line_ff} == side_m1);
   assign col_last    = ({1'b0, col_ff} == side_m1);
   assign read_ok     = done_ff && ({1'b0, req_row_index} < side);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         idwt97_pkg::ST_IDLE: begin
            if (req_accept) begin
               priority if (req_command == idwt97_pkg::CMD_RUN) begin
                  state_in = idwt97_pkg::ST_LOAD;
               end else if (req_command == idwt97_pkg::CMD_READ && read_ok) begin
                  state_in = idwt97_pkg::ST_RD_ADDR;
               end else begin
                  state_in = idwt97_pkg::ST_IDLE;
               end
            end
         end
         idwt97_pkg::ST_LOAD: begin
            if (load_done) state_in = idwt97_pkg::ST_FILT;
         end
         idwt97_pkg::ST_FILT: begin
            if (sample_done && ({1'b0, pos_ff} == side_m1)) begin
               state_in = (line_last && pass_ff) ? idwt97_pkg::ST_ACK : idwt97_pkg::ST_LOAD;
            end
         end
         idwt97_pkg::ST_ACK: begin
            if (slot_free) state_in = idwt97_pkg::ST_IDLE;
         end
         idwt97_pkg::ST_RD_ADDR: begin
            state_in = idwt97_pkg::ST_RD_DATA;
         end
         idwt97_pkg::ST_RD_DATA: begin
            if (slot_free) begin
               state_in = col_last ? idwt97_pkg::ST_IDLE : idwt97_pkg::ST_RD_ADDR;
            end
         end
         default: state_in = idwt97_pkg::ST_IDLE;
      endcase
   end

   // Tap position with whole-sample mirror at both ends
   always_comb begin
      is_low  = (step_ff < 5'(idwt97_pkg::LOW_COUNT));
      tap_pos = is_low ? ($signed({2'b00, pos_ff}) + $signed(8'(step_ff)) - 8'sd3)
                       : ($signed({2'b00, pos_ff}) + $signed(8'(step_ff)) - 8'sd11);
      mag     = tap_pos[7] ? SW'(-tap_pos) : SW'(tap_pos);
      fold_pos = (mag > side_m1) ? SW'({side_m1, 1'b0} - {1'b0, mag}) : mag;
      // Low taps land on odd positions, high taps on even ones
      tap_used = is_low ? (pos_ff[0] == step_ff[0]) : (pos_ff[0] != step_ff[0]);
      line_ra  = is_low ? fold_pos[IW:1] : (side[IW:1] + fold_pos[IW:1]);
   end

   // Datapath controls
   always_comb begin
      elem = (state_ff == idwt97_pkg::ST_FILT) ? pos_ff : idx_ff[IW-1:0];
      store_ra = pass_ff ? {elem, line_ff} : {line_ff, elem};
      if (state_ff == idwt97_pkg::ST_RD_ADDR || state_ff == idwt97_pkg::ST_RD_DATA) begin
         store_ra = {row_ff, col_ff};
      end
      store_we = 1'b0;
      store_wa = store_ra;
      store_wd = mac_result;
      if (req_accept && req_command == idwt97_pkg::CMD_WRITE) begin
         store_we = 1'b1;
         store_wa = {req_row_index, req_col_index};
         store_wd = req_coeff_value;
      end else if (state_ff == idwt97_pkg::ST_FILT && sample_done) begin
         store_we = 1'b1;
      end
      mac_ctrl.issue = (state_ff == idwt97_pkg::ST_FILT) &&
                       (step_ff < idwt97_pkg::STEP_ISSUE_END);
      mac_ctrl.clear = (state_ff != idwt97_pkg::ST_FILT) || sample_done;
      rsp_load = slot_free && (state_ff == idwt97_pkg::ST_ACK ||
                               state_ff == idwt97_pkg::ST_RD_DATA);
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_wa] <= store_wd;
      store_rd_ff <= store_mem[store_ra];
   end

   always_ff @(posedge clock) begin
      if (state_ff == idwt97_pkg::ST_LOAD && idx_ff != '0) begin
         line_mem[IW'(idx_ff - SW'(1))] <= store_rd_ff;
      end
      line_rd_ff <= line_mem[line_ra];
      tap_ff     <= tap_used ? idwt97_pkg::tap_value(step_ff[3:0]) : '0;
   end

   idwt97_mac u_mac (
      .clock   (clock),
      .operand (line_rd_ff),
      .tap     (tap_ff),
      .ctrl    (mac_ctrl),
      .result  (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= idwt97_pkg::ST_IDLE;
         block_size_ff <= idwt97_pkg::SIDE_RESET;
         done_ff       <= 1'b0;
         pass_ff       <= 1'b0;
         line_ff       <= '0;
         idx_ff        <= '0;
         pos_ff        <= '0;
         step_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) block_size_ff <= csr_block_size;
         if (req_accept && req_command == idwt97_pkg::CMD_WRITE) done_ff <= 1'b0;
         unique case (state_ff)
            idwt97_pkg::ST_IDLE: begin
               if (req_accept) begin
                  pass_ff <= 1'b0;
                  line_ff <= '0;
                  idx_ff  <= '0;
                  row_ff  <= req_row_index;
                  col_ff  <= '0;
               end
            end
            idwt97_pkg::ST_LOAD: begin
               if (load_done) begin
                  idx_ff  <= '0;
                  pos_ff  <= '0;
                  step_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
               end
            end
            idwt97_pkg::ST_FILT: begin
               if (sample_done) begin
                  step_ff <= '0;
                  if ({1'b0, pos_ff} == side_m1) begin
                     pos_ff <= '0;
                     if (line_last) begin
                        line_ff <= '0;
                        pass_ff <= 1'b1;
                        if (pass_ff) done_ff <= 1'b1;
                     end else begin
                        line_ff <= line_ff + IW'(1);
                     end
                  end else begin
                     pos_ff <= pos_ff + IW'(1);
                  end
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            idwt97_pkg::ST_RD_DATA: begin
               if (rsp_load) col_ff <= col_ff + IW'(1);
            end
            idwt97_pkg::ST_ACK, idwt97_pkg::ST_RD_ADDR: begin
            end
            default: begin
            end
         endcase
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (state_ff == idwt97_pkg::ST_ACK) begin
            rsp_value_ff <= '0;
            rsp_row_ff   <= '0;
            rsp_col_ff   <= '0;
            rsp_last_ff  <= 1'b1;
         end else begin
            rsp_value_ff <= store_rd_ff;
            rsp_row_ff   <= row_ff;
            rsp_col_ff   <= col_ff;
            rsp_last_ff  <= col_last;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_last_flag    = rsp_last_ff;

   a_filt_pos_in_side: assert property (@(posedge clock) disable iff (reset)
      (state_ff == idwt97_pkg::ST_FILT) |-> ({1'b0, pos_ff} < side))
      else $error("filter position beyond block side");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == idwt97_pkg::ST_LOAD) |-> (idx_ff <= side))
      else $error("line load count overran");

   a_done_from_filter: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(state_ff == idwt97_pkg::ST_FILT))
      else $error("transform done set outside filtering");

   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == idwt97_pkg::ST_ACK && rsp_load) |=> (rsp_valid && rsp_last_flag))
      else $error("run acknowledgement lost last flag");

endmodule

`default_nettype wire
